[rtl/fud_pkg.sv]
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types, character codes, token kinds and the loose hex rule of the
// form url-decode parser.
// ----------------------------------------------------------------------------
package fud_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] HEX_TEN  = 8'd10;
    localparam int         NIB_W    = 4;

    localparam logic [2:0] TK_BYTE    = 3'd0;
    localparam logic [2:0] TK_NAME    = 3'd1;
    localparam logic [2:0] TK_COMMIT  = 3'd2;
    localparam logic [2:0] TK_DISCARD = 3'd3;
    localparam logic [2:0] TK_FINAL   = 3'd4;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_PCT  = 2'd1;
    localparam logic [1:0] ESC_HELD = 2'd2;

    localparam int MAX_RES = 3;
    localparam int QDEPTH  = 8;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int RCNT_W  = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       fset;
        logic       last;
    } t_res;

    typedef struct packed {
        logic emit;
        t_res tok;
        logic set_ns;
        logic clr_ns;
        logic esc;
    } t_plain;

    function automatic logic [7:0] hex_val(input logic [7:0] c);
        logic [7:0] lc;
        lc = c;
        if (c >= CH_0 && c <= CH_9) begin
            return c - CH_0;
        end
        if (c >= CH_UA && c <= CH_UZ) begin
            lc = c + (CH_LA - CH_UA);
        end
        return lc - CH_LA + HEX_TEN;
    endfunction

    function automatic t_plain plain_fn(input logic [7:0] b, input logic ns);
        t_plain p;
        p = '0;
        if (b == CH_PCT) begin
            p.esc = 1'b1;
        end else if (b == CH_PLUS) begin
            p.emit      = 1'b1;
            p.tok.kind  = TK_BYTE;
            p.tok.data  = CH_SPACE;
        end else if (b == CH_EQ) begin
            p.emit      = 1'b1;
            p.tok.kind  = TK_NAME;
            p.set_ns    = 1'b1;
        end else if (b == CH_AMP) begin
            p.emit      = 1'b1;
            p.tok.kind  = ns ? TK_COMMIT : TK_DISCARD;
            p.clr_ns    = 1'b1;
        end else begin
            p.emit      = 1'b1;
            p.tok.kind  = TK_BYTE;
            p.tok.data  = b;
        end
        return p;
    endfunction

endpackage

[rtl/fud_in_if.sv]
// ----------------------------------------------------------------------------
// fud_in_if
// Input channel: zero or one raw text byte per word, with end-of-text mark.
// ----------------------------------------------------------------------------
interface fud_in_if import fud_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;

    modport source (output valid, text_byte, byte_present, end_of_text, input ready);
    modport sink   (input valid, text_byte, byte_present, end_of_text, output ready);
endinterface

[rtl/fud_out_if.sv]
// ----------------------------------------------------------------------------
// fud_out_if
// Output channel: one token per word.
// ----------------------------------------------------------------------------
interface fud_out_if import fud_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] token_kind;
    logic [7:0] decoded_byte;
    logic       final_name_set;
    logic       last_result;

    modport source (output valid, token_kind, decoded_byte, final_name_set, last_result,
                    input ready);
    modport sink   (input valid, token_kind, decoded_byte, final_name_set, last_result,
                    output ready);
endinterface

[rtl/form_urldecode_parser.sv]
// ----------------------------------------------------------------------------
// form_urldecode_parser
// Decodes form-encoded text byte by byte into tokens: decoded bytes, name
// ended, pair committed, segment discarded and final entry.
// ----------------------------------------------------------------------------
// The block takes one text word per cycle whenever its 8-word token queue has
// room for three more tokens; each word is decoded in the cycle it is taken and
// its zero to three tokens enter the queue together. The queue hands out one
// token per cycle while the receiver is ready, so a text whose words average
// above one token each runs at that output rate. Tokens leave in text order,
// and the last token of each input word carries last_result.
module form_urldecode_parser import fud_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fud_in_if.sink    i_in,
    fud_out_if.source o_out
);

    logic [1:0]        r_ep, n_ep;
    logic [7:0]        r_fh, n_fh;
    logic              r_ns, n_ns;
    t_res              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_count, n_count;
    t_res              w_slot [MAX_RES];
    logic [RCNT_W-1:0] w_cnt;
    logic              w_acc, w_pop;

    assign i_in.ready = (r_count <= QCNT_W'(QDEPTH - MAX_RES));
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_pop      = o_out.valid && o_out.ready;

    always_comb begin
        logic [1:0]        ep;
        logic [7:0]        fh;
        logic              ns;
        logic [7:0]        b;
        logic [RCNT_W-1:0] cnt;
        t_plain            pl;
        ep  = r_ep;
        fh  = r_fh;
        ns  = r_ns;
        b   = i_in.text_byte;
        cnt = '0;
        pl  = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            w_slot[k] = '0;
        end

        if (i_in.byte_present) begin
            if (ep == ESC_PCT) begin
                if (b == 8'd0) begin
                    ep = ESC_NONE;
                    w_slot[cnt].kind = TK_BYTE;
                    cnt = cnt + RCNT_W'(1);
                end else begin
                    fh = b;
                    ep = ESC_HELD;
                end
            end else if (ep == ESC_HELD) begin
                ep = ESC_NONE;
                if (b == 8'd0) begin
                    pl = plain_fn(fh, ns);
                    if (pl.set_ns) ns = 1'b1;
                    if (pl.clr_ns) ns = 1'b0;
                    if (pl.emit) begin
                        w_slot[cnt] = pl.tok;
                        cnt = cnt + RCNT_W'(1);
                    end
                    w_slot[cnt].kind = TK_BYTE;
                    cnt = cnt + RCNT_W'(1);
                end else begin
                    w_slot[cnt].kind = TK_BYTE;
                    w_slot[cnt].data = (hex_val(fh) << NIB_W) | hex_val(b);
                    cnt = cnt + RCNT_W'(1);
                end
            end else begin
                pl = plain_fn(b, ns);
                if (pl.esc) ep = ESC_PCT;
                if (pl.set_ns) ns = 1'b1;
                if (pl.clr_ns) ns = 1'b0;
                if (pl.emit) begin
                    w_slot[cnt] = pl.tok;
                    cnt = cnt + RCNT_W'(1);
                end
            end
        end

        if (i_in.end_of_text) begin
            if (ep == ESC_HELD) begin
                pl = plain_fn(fh, ns);
                if (pl.set_ns) ns = 1'b1;
                if (pl.clr_ns) ns = 1'b0;
                if (pl.emit) begin
                    w_slot[cnt] = pl.tok;
                    cnt = cnt + RCNT_W'(1);
                end
            end
            w_slot[cnt].kind = TK_FINAL;
            w_slot[cnt].fset = ns;
            cnt = cnt + RCNT_W'(1);
            ep = ESC_NONE;
            fh = '0;
            ns = 1'b0;
        end

        if (cnt != '0) begin
            w_slot[cnt - RCNT_W'(1)].last = 1'b1;
        end

        n_ep  = ep;
        n_fh  = fh;
        n_ns  = ns;
        w_cnt = cnt;
    end

    assign n_count = r_count + (w_acc ? QCNT_W'(w_cnt) : '0) - QCNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep    <= ESC_NONE;
            r_fh    <= '0;
            r_ns    <= 1'b0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_acc) begin
                r_ep <= n_ep;
                r_fh <= n_fh;
                r_ns <= n_ns;
                r_wp <= r_wp + QPTR_W'(w_cnt);
            end
            if (w_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (w_acc && (RCNT_W'(k) < w_cnt)) begin
                r_q[r_wp + QPTR_W'(k)] <= w_slot[k];
            end
        end
    end

    assign o_out.valid          = (r_count != '0);
    assign o_out.token_kind     = r_q[r_rp].kind;
    assign o_out.decoded_byte   = r_q[r_rp].data;
    assign o_out.final_name_set = r_q[r_rp].fset;
    assign o_out.last_result    = r_q[r_rp].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("token queue overfilled");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.end_of_text) |=> (r_ep == ESC_NONE && !r_ns))
        else $error("state not cleared after end of text");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ep == ESC_NONE || r_ep == ESC_PCT || r_ep == ESC_HELD)
        else $error("illegal escape phase");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.end_of_text) |-> (w_cnt != '0))
        else $error("end of text produced no token");

endmodule

[tb/sv/tb_form_urldecode_parser.sv]
// ----------------------------------------------------------------------------
// tb_form_urldecode_parser
// Drives form-encoded text words into the parser and checks every token it
// emits against an in-bench model of the decoder. Directed words cover the
// plain, plus, name, commit, discard and escape paths. They also cover escapes
// cut by a zero byte, truncated escapes at end of text and empty final words.
// Random texts follow, mostly well-formed name=value pairs with noise mixed in.
// Both channels idle at random, and the token side has one long hold-off.
// ----------------------------------------------------------------------------
module tb_form_urldecode_parser import fud_pkg::*; ();

    class token_scoreboard;
        logic [1:0] esc_state;
        logic [7:0] held_byte;
        logic       name_open;
        t_res       word_toks[$];
        t_res       pending[$];
        int         errors;

        function new();
            clear_text();
            errors = 0;
        endfunction

        function void clear_text();
            esc_state = ESC_NONE;
            held_byte = '0;
            name_open = 1'b0;
        endfunction

        function void add_token(logic [2:0] kind, logic [7:0] data, logic fset);
            t_res t;
            t.kind = kind;
            t.data = data;
            t.fset = fset;
            t.last = 1'b0;
            word_toks.push_back(t);
        endfunction

        function logic [7:0] loose_nibble(logic [7:0] c);
            logic [7:0] folded;
            if (c >= CH_0 && c <= CH_9) begin
                return c - CH_0;
            end
            folded = (c >= CH_UA && c <= CH_UZ) ? (c | 8'h20) : c;
            return folded - CH_LA + HEX_TEN;
        endfunction

        function void take_plain(logic [7:0] b);
            case (b)
                CH_PCT: esc_state = ESC_PCT;
                CH_PLUS: add_token(TK_BYTE, CH_SPACE, 1'b0);
                CH_EQ: begin
                    name_open = 1'b1;
                    add_token(TK_NAME, 8'h00, 1'b0);
                end
                CH_AMP: begin
                    add_token(name_open ? TK_COMMIT : TK_DISCARD, 8'h00, 1'b0);
                    name_open = 1'b0;
                end
                default: add_token(TK_BYTE, b, 1'b0);
            endcase
        endfunction

        // release a held escape byte as plain; a held percent is dropped
        function void flush_held();
            esc_state = ESC_NONE;
            take_plain(held_byte);
            esc_state = ESC_NONE;
        endfunction

        function void note_word(logic [7:0] b, logic present, logic eot);
            logic [7:0] hi;
            logic [7:0] lo;
            t_res       t;
            word_toks.delete();
            if (present) begin
                case (esc_state)
                    ESC_PCT: begin
                        if (b == 8'h00) begin
                            esc_state = ESC_NONE;
                            take_plain(b);
                        end else begin
                            held_byte = b;
                            esc_state = ESC_HELD;
                        end
                    end
                    ESC_HELD: begin
                        if (b == 8'h00) begin
                            flush_held();
                            take_plain(b);
                        end else begin
                            hi = loose_nibble(held_byte);
                            lo = loose_nibble(b);
                            esc_state = ESC_NONE;
                            add_token(TK_BYTE, {hi[3:0], 4'b0000} | lo, 1'b0);
                        end
                    end
                    default: take_plain(b);
                endcase
            end
            if (eot) begin
                if (esc_state == ESC_HELD) begin
                    flush_held();
                end
                add_token(TK_FINAL, 8'h00, name_open);
                clear_text();
            end
            if (word_toks.size() > 0) begin
                t = word_toks.pop_back();
                t.last = 1'b1;
                word_toks.push_back(t);
            end
            foreach (word_toks[i]) begin
                pending.push_back(word_toks[i]);
            end
        endfunction

        function void check_token(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected token: expected none, actual kind %0d byte %02h",
                         $time, got.kind, got.data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: token_kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.data !== want.data) begin
                $display("%0t: decoded_byte expected %02h actual %02h",
                         $time, want.data, got.data);
                errors++;
            end
            if (got.fset !== want.fset) begin
                $display("%0t: final_name_set expected %0d actual %0d",
                         $time, want.fset, got.fset);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_result expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    fud_in_if  text_bus();
    fud_out_if token_bus();

    form_urldecode_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_bus),
        .o_out   (token_bus)
    );

    token_scoreboard sb = new();
    bit              no_idle = 1'b0;
    bit              hold_off_req = 1'b0;
    int              sent_count = 0;
    logic [7:0]      text_q[$];
    string           name_chars = "abcdefxyzABCFXZ0189-_.~";
    string           hex_chars = "0123456789abcdefABCDEF";

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("form_urldecode_parser test failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic present, input logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            text_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_bus.valid        <= 1'b1;
        text_bus.text_byte    <= b;
        text_bus.byte_present <= present;
        text_bus.end_of_text  <= eot;
        do @(posedge i_clk); while (!text_bus.ready);
        sb.note_word(b, present, eot);
        if (present || eot) begin
            sent_count++;
        end
    endtask

    // hold the sender until every expected token is out
    task automatic wait_drained();
        text_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    function automatic void push_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            text_q.push_back(name_chars[$urandom_range(0, name_chars.len() - 1)]);
        end else if (r < 60) begin
            text_q.push_back(CH_PLUS);
        end else if (r < 75) begin
            text_q.push_back(CH_PCT);
            text_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
            text_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
        end else if (r < 85) begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end else if (r < 90) begin
            text_q.push_back(CH_PCT);
            if ($urandom_range(0, 1)) begin
                text_q.push_back(8'($urandom_range(1, 255)));
            end
            text_q.push_back(8'h00);
        end else if (r < 94) begin
            text_q.push_back(CH_EQ);
        end else if (r < 97) begin
            text_q.push_back(CH_PCT);
            text_q.push_back(8'($urandom_range(0, 255)));
            text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            text_q.push_back(CH_AMP);
        end
    endfunction

    task automatic send_text();
        int nseg;
        int n;
        bit empty_final;
        text_q.delete();
        nseg = $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++) begin
            if (s > 0) begin
                text_q.push_back(CH_AMP);
            end
            n = $urandom_range(0, 4);
            repeat (n) push_text_char();
            if ($urandom_range(0, 9) < 8) begin
                text_q.push_back(CH_EQ);
            end
            n = $urandom_range(0, 5);
            repeat (n) push_text_char();
        end
        case ($urandom_range(0, 9))
            0: text_q.push_back(CH_PCT);
            1: begin
                text_q.push_back(CH_PCT);
                text_q.push_back(8'($urandom_range(1, 255)));
            end
            default: ;
        endcase
        empty_final = (text_q.size() == 0) || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < text_q.size(); i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_word(text_q[i], 1'b1, !empty_final && (i == text_q.size() - 1));
        end
        if (empty_final) begin
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    initial begin
        int   stall_left;
        t_res got;
        stall_left = 0;
        token_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && token_bus.valid && token_bus.ready) begin
                got.kind = token_bus.token_kind;
                got.data = token_bus.decoded_byte;
                got.fset = token_bus.final_name_set;
                got.last = token_bus.last_result;
                sb.check_token(got);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = 300;
            end else if (stall_left == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                token_bus.ready <= 1'b0;
            end else begin
                token_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n               <= 1'b0;
        text_bus.valid        <= 1'b0;
        text_bus.text_byte    <= 8'h00;
        text_bus.byte_present <= 1'b0;
        text_bus.end_of_text  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(8'h6B, 1'b1, 1'b0);
        send_word(CH_EQ, 1'b1, 1'b0);
        send_word(CH_EQ, 1'b1, 1'b0);
        send_word(CH_PLUS, 1'b1, 1'b0);
        send_word(CH_PCT, 1'b1, 1'b0);
        send_word(8'h41, 1'b1, 1'b0);
        send_word(8'h66, 1'b1, 1'b0);
        send_word(CH_AMP, 1'b1, 1'b0);
        send_word(CH_AMP, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(CH_PCT, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(CH_PCT, 1'b1, 1'b0);
        send_word(CH_EQ, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(CH_PCT, 1'b1, 1'b0);
        send_word(CH_PCT, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(CH_PCT, 1'b1, 1'b0);
        send_word(8'h7A, 1'b1, 1'b0);
        send_word(8'h39, 1'b1, 1'b1);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(CH_PCT, 1'b1, 1'b1);
        send_word(CH_PCT, 1'b1, 1'b0);
        send_word(8'h47, 1'b1, 1'b1);
        send_word(8'h5A, 1'b0, 1'b1);
        wait_drained();

        no_idle = 1'b1;
        while (sent_count < 100) send_text();
        no_idle = 1'b0;
        hold_off_req = 1'b1;
        while (sent_count < 170) send_text();
        wait_drained();
        while (sent_count < 320) send_text();

        text_bus.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("form_urldecode_parser test passed");
        end else begin
            $display("form_urldecode_parser test failed");
        end
        $finish;
    end

endmodule

[form_urldecode_parser.f]
rtl/fud_pkg.sv
rtl/fud_in_if.sv
rtl/fud_out_if.sv
rtl/form_urldecode_parser.sv
tb/sv/tb_form_urldecode_parser.sv
